// ===== hw/rtl/ros_pkg.sv =====
// Shared types and constants for the random organisation sweep block.
package ros_pkg;

   localparam int POS_W         = 26;
   localparam int IDX_W         = 7;
   localparam int RND_W         = 16;
   localparam int CNT_W         = 8;
   localparam int CSR_IDX_W     = 2;
   localparam int PROD_W        = POS_W + RND_W;
   localparam int PARTICLES_DEF = 128;

   localparam logic [POS_W-1:0] POS_MAX     = '1;
   localparam logic [POS_W-1:0] SPAN_RST    = POS_W'(65536000);
   localparam logic [POS_W-1:0] MIN_GAP_RST = POS_W'(65536);
   localparam logic [POS_W-1:0] STEP_RST    = POS_W'(16384);

   localparam logic [CSR_IDX_W-1:0] CSR_SPAN    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_STEP    = CSR_IDX_W'(2);

   typedef enum logic [1:0] {
      ACT_WRITE    = 2'd0,
      ACT_READ     = 2'd1,
      ACT_ACTIVITY = 2'd2,
      ACT_DISPLACE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_FIRST,
      KIND_LAST,
      KIND_MIDDLE
   } end_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACT_BASE,
      ST_ACT_RUN,
      ST_ACT_END,
      ST_DISP_LOAD,
      ST_DISP_REFL,
      ST_DISP_ORDER,
      ST_WR_SELF,
      ST_WR_NBR,
      ST_WR_PREV,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic         load_x;
      logic         load_new;
      end_kind_type kind;
   } move_ctl_type;

endpackage

// ===== hw/rtl/ros_move_unit.sv =====
// Displacement arithmetic: trial position, end reflection and range clamp.
module ros_move_unit (
   input  logic                          clock,
   input  ros_pkg::move_ctl_type         ctl,
   input  logic [ros_pkg::POS_W-1:0]     pos_cur,
   input  logic [ros_pkg::PROD_W-1:0]    prod,
   input  logic [ros_pkg::POS_W-1:0]     step_size,
   input  logic [ros_pkg::POS_W-1:0]     span,
   output logic [ros_pkg::POS_W-1:0]     new_pos
);

   localparam int XW = ros_pkg::POS_W + 3;
   localparam int SW = ros_pkg::PROD_W - (ros_pkg::RND_W - 1);

   logic signed [XW-1:0]         x_in;
   logic signed [XW-1:0]         x_ff;
   logic signed [XW-1:0]         refl;
   logic signed [XW-1:0]         span_s;
   logic signed [XW-1:0]         span2_s;
   logic [ros_pkg::POS_W-1:0]    new_in;
   logic [ros_pkg::POS_W-1:0]    new_ff;

   // 2*step*r >> 16 is step*r >> 15
   assign x_in = $signed({3'b000, pos_cur}) - $signed({3'b000, step_size})
               + $signed({{(XW-SW){1'b0}}, prod[ros_pkg::PROD_W-1:ros_pkg::RND_W-1]});

   assign span_s  = $signed({3'b000, span});
   assign span2_s = $signed({2'b00, span, 1'b0});

   always_comb begin
      refl = x_ff;
      case (ctl.kind)
         ros_pkg::KIND_FIRST: begin
            if (x_ff < 0) refl = -x_ff;
         end
         ros_pkg::KIND_LAST: begin
            if (x_ff > span_s) refl = span2_s - x_ff;
         end
         default: refl = x_ff;
      endcase
      if (refl < 0) begin
         new_in = '0;
      end else if (refl > $signed({3'b000, ros_pkg::POS_MAX})) begin
         new_in = ros_pkg::POS_MAX;
      end else begin
         new_in = refl[ros_pkg::POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_x)   x_ff   <= x_in;
      if (ctl.load_new) new_ff <= new_in;
   end

   assign new_pos = new_ff;

endmodule

// ===== hw/rtl/random_organization_sweep_top.sv =====
// Top level of the random organisation sweep block: memories, sequencer and result register.
//
// One-dimensional random organisation engine. Particle positions (unsigned Q10.16, 26 bits)
// live in a dual-read, single-write position memory; activity flags live in a one-bit flag
// memory. Transactions are taken one at a time; req_ready is high only while the sequencer
// is idle, and a finished result waits in the rsp_ output register so the next transaction
// can be taken and worked on meanwhile. Steps per transaction: write and read go from idle
// to the result state; activity streams one memory read per particle through a gap window;
// displace goes to the result state when no sweep is open, after loading the flag when the
// visited particle is inactive, and for an active particle runs load, reflect and order
// states and then writes back. The write-back uses the single write port of the position
// memory: the particle, its upper (or lower) neighbour and for inner particles its lower
// neighbour are written back one per cycle. A result not yet taken holds the sequencer in
// its result state. Positions are undefined until written; the flag memory needs no
// clearing pass, as flags are read only by a displace, which needs a sweep opened by an
// activity pass that has written every flag. Configuration writes are always taken
// (csr_ready is tied high); index 3 is ignored.
module random_organization_sweep_top #(
   parameter int PARTICLES = ros_pkg::PARTICLES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // input transactions
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_action,
   input  logic [ros_pkg::IDX_W-1:0]        req_index,
   input  logic [ros_pkg::POS_W-1:0]        req_position,
   input  logic [ros_pkg::RND_W-1:0]        req_rnd,
   // result transactions
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ros_pkg::POS_W-1:0]        rsp_read_value,
   output logic [ros_pkg::CNT_W-1:0]        rsp_active_count,
   output logic                             rsp_moved,
   output logic                             rsp_sweep_done,
   output logic                             rsp_error,
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ros_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ros_pkg::POS_W-1:0]        csr_data
);

   localparam int AW = $clog2(PARTICLES);
   localparam int CW = $clog2(PARTICLES + 1);
   localparam int PW = ros_pkg::POS_W;
   localparam logic [AW-1:0] LAST_ADDR  = AW'(PARTICLES - 1);
   localparam logic [CW-1:0] CURSOR_END = CW'(PARTICLES);

   // ---------------------------------------------------------------- storage
   logic [PW-1:0] pos_mem [PARTICLES];
   logic          flag_mem [PARTICLES];

   // ---------------------------------------------------------------- control state
   ros_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]       cursor_ff;
   logic                rsp_valid_ff;
   logic [PW-1:0]       span_ff, min_gap_ff, step_ff;

   // ---------------------------------------------------------------- payload registers
   logic [AW-1:0]                 idx_addr_ff, p_addr_ff, nbr_addr_ff, prev_addr_ff, k_ff;
   ros_pkg::end_kind_type         kind_ff;
   logic                          rd_ok_ff;
   logic [ros_pkg::PROD_W-1:0]    prod_ff;
   logic                          res_moved_ff, res_done_ff, res_err_ff;
   logic [ros_pkg::CNT_W-1:0]     count_ff;
   logic                          wrap_ff, cprev_ff;
   logic [PW-1:0]                 prev_pos_ff;
   logic [PW-1:0]                 wp_ff, wb_ff, wm_ff;
   logic [PW-1:0]                 rd_a_ff, rd_b_ff;
   logic                          flag_rd_ff;
   logic [PW-1:0]                 rsp_read_value_ff;
   logic [ros_pkg::CNT_W-1:0]     rsp_active_count_ff;
   logic                          rsp_moved_ff, rsp_sweep_done_ff, rsp_error_ff;

   // ---------------------------------------------------------------- combinational
   logic                   req_accept, out_free, idx_ok_in, cursor_open;
   ros_pkg::action_type    action_in;
   logic [AW-1:0]          idx_addr_in, p_in, nbr_in, prev_in;
   ros_pkg::end_kind_type  kind_in;
   logic                   gap_close, wrap_close;
   logic [AW-1:0]          rd_a_addr, rd_b_addr, flag_raddr;
   logic                   pos_we, flag_we, flag_wdata;
   logic [AW-1:0]          pos_waddr, flag_waddr;
   logic [PW-1:0]          pos_wdata;
   ros_pkg::move_ctl_type  move_ctl;
   logic [PW-1:0]          new_pos;
   logic [PW-1:0]          lo_val, hi_val;
   logic [PW-1:0]          wp_in, wb_in, wm_in;

   // signed hi - lo below min_gap: unordered pairs count as too close
   function automatic logic too_close(input logic [PW-1:0] lo, input logic [PW-1:0] hi,
                                      input logic [PW-1:0] gap);
      logic signed [PW+1:0] diff;
      diff = $signed({2'b00, hi}) - $signed({2'b00, lo});
      return diff < $signed({2'b00, gap});
   endfunction

   assign req_ready   = (state_ff == ros_pkg::ST_IDLE);
   assign req_accept  = req_valid & req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign action_in   = ros_pkg::action_type'(req_action);
   assign idx_ok_in   = int'(req_index) < PARTICLES;
   assign idx_addr_in = AW'(req_index);
   assign cursor_open = cursor_ff < CURSOR_END;
   assign csr_ready   = 1'b1;

   // sweep order: 0, last, then 1 .. last-1
   always_comb begin
      if (cursor_ff == CW'(0)) begin
         p_in    = '0;
         kind_in = ros_pkg::KIND_FIRST;
      end else if (cursor_ff == CW'(1)) begin
         p_in    = LAST_ADDR;
         kind_in = ros_pkg::KIND_LAST;
      end else begin
         p_in    = AW'(cursor_ff - CW'(1));
         kind_in = ros_pkg::KIND_MIDDLE;
      end
      nbr_in  = (kind_in == ros_pkg::KIND_LAST) ? LAST_ADDR - AW'(1) : p_in + AW'(1);
      prev_in = (kind_in == ros_pkg::KIND_MIDDLE) ? p_in - AW'(1) : p_in;
   end

   // gap tests for the activity pass
   assign gap_close = too_close(prev_pos_ff, rd_a_ff, min_gap_ff);
   always_comb begin
      logic signed [PW+2:0] wrap;
      wrap = $signed({3'b000, span_ff}) - $signed({3'b000, rd_a_ff})
           + $signed({3'b000, rd_b_ff});
      wrap_close = wrap < $signed({3'b000, min_gap_ff});
   end

   // reorder after a move; rd_b holds the neighbour, rd_a the lower neighbour
   always_comb begin
      wm_in = rd_a_ff;
      case (kind_ff)
         ros_pkg::KIND_LAST: begin
            if (new_pos < rd_b_ff) begin
               wp_in = rd_b_ff;
               wb_in = new_pos;
            end else begin
               wp_in = new_pos;
               wb_in = rd_b_ff;
            end
            lo_val = wp_in;
            hi_val = wb_in;
         end
         default: begin
            if (new_pos > rd_b_ff) begin
               lo_val = rd_b_ff;
               hi_val = new_pos;
            end else begin
               lo_val = new_pos;
               hi_val = rd_b_ff;
            end
            wb_in = hi_val;
            wp_in = lo_val;
            if (kind_ff == ros_pkg::KIND_MIDDLE && lo_val < rd_a_ff) begin
               wm_in = lo_val;
               wp_in = rd_a_ff;
            end
         end
      endcase
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ros_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (action_in)
                  ros_pkg::ACT_ACTIVITY: state_in = ros_pkg::ST_ACT_BASE;
                  ros_pkg::ACT_DISPLACE: state_in = cursor_open ? ros_pkg::ST_DISP_LOAD
                                                                : ros_pkg::ST_RESP;
                  default:               state_in = ros_pkg::ST_RESP;
               endcase
            end
         end
         ros_pkg::ST_ACT_BASE:   state_in = ros_pkg::ST_ACT_RUN;
         ros_pkg::ST_ACT_RUN:    if (k_ff == LAST_ADDR) state_in = ros_pkg::ST_ACT_END;
         ros_pkg::ST_ACT_END:    state_in = ros_pkg::ST_RESP;
         ros_pkg::ST_DISP_LOAD:  state_in = flag_rd_ff ? ros_pkg::ST_DISP_REFL : ros_pkg::ST_RESP;
         ros_pkg::ST_DISP_REFL:  state_in = ros_pkg::ST_DISP_ORDER;
         ros_pkg::ST_DISP_ORDER: state_in = ros_pkg::ST_WR_SELF;
         ros_pkg::ST_WR_SELF:    state_in = ros_pkg::ST_WR_NBR;
         ros_pkg::ST_WR_NBR:     state_in = (kind_ff == ros_pkg::KIND_MIDDLE) ? ros_pkg::ST_WR_PREV
                                                                              : ros_pkg::ST_RESP;
         ros_pkg::ST_WR_PREV:    state_in = ros_pkg::ST_RESP;
         ros_pkg::ST_RESP:       if (out_free) state_in = ros_pkg::ST_IDLE;
         default:                state_in = ros_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- state outputs
   always_comb begin
      rd_a_addr  = prev_addr_ff;
      rd_b_addr  = nbr_addr_ff;
      flag_raddr = p_in;
      pos_we     = 1'b0;
      pos_waddr  = p_addr_ff;
      pos_wdata  = wp_ff;
      flag_we    = 1'b0;
      flag_waddr = k_ff - AW'(1);
      flag_wdata = cprev_ff | gap_close;
      move_ctl.load_x   = 1'b0;
      move_ctl.load_new = 1'b0;
      move_ctl.kind     = kind_ff;
      unique case (state_ff)
         ros_pkg::ST_IDLE: begin
            unique case (action_in)
               ros_pkg::ACT_ACTIVITY: begin
                  rd_a_addr = LAST_ADDR;
                  rd_b_addr = '0;
               end
               ros_pkg::ACT_DISPLACE: begin
                  rd_a_addr = p_in;
                  rd_b_addr = nbr_in;
               end
               default: rd_a_addr = idx_addr_in;
            endcase
            if (req_accept && action_in == ros_pkg::ACT_WRITE && idx_ok_in) begin
               pos_we    = 1'b1;
               pos_waddr = idx_addr_in;
               pos_wdata = req_position;
            end
         end
         ros_pkg::ST_ACT_BASE: rd_a_addr = AW'(1);
         ros_pkg::ST_ACT_RUN: begin
            rd_a_addr = (k_ff == LAST_ADDR) ? k_ff : k_ff + AW'(1);
            flag_we   = 1'b1;
         end
         ros_pkg::ST_ACT_END: begin
            rd_a_addr  = k_ff;
            flag_we    = 1'b1;
            flag_waddr = LAST_ADDR;
            flag_wdata = cprev_ff | wrap_ff;
         end
         ros_pkg::ST_DISP_LOAD: move_ctl.load_x   = 1'b1;
         ros_pkg::ST_DISP_REFL: move_ctl.load_new = 1'b1;
         ros_pkg::ST_DISP_ORDER: begin
         end
         ros_pkg::ST_WR_SELF: pos_we = 1'b1;
         ros_pkg::ST_WR_NBR: begin
            pos_we    = 1'b1;
            pos_waddr = nbr_addr_ff;
            pos_wdata = wb_ff;
         end
         ros_pkg::ST_WR_PREV: begin
            pos_we    = 1'b1;
            pos_waddr = prev_addr_ff;
            pos_wdata = wm_ff;
         end
         ros_pkg::ST_RESP: rd_a_addr = idx_addr_ff;  // keeps read data for the result
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
      rd_a_ff <= pos_mem[rd_a_addr];
      rd_b_ff <= pos_mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[flag_waddr] <= flag_wdata;
      flag_rd_ff <= flag_mem[flag_raddr];
   end

   ros_move_unit u_move (
      .clock     (clock),
      .ctl       (move_ctl),
      .pos_cur   (rd_a_ff),
      .prod      (prod_ff),
      .step_size (step_ff),
      .span      (span_ff),
      .new_pos   (new_pos)
   );

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ros_pkg::ST_IDLE;
         cursor_ff    <= CURSOR_END;
         rsp_valid_ff <= 1'b0;
         span_ff      <= ros_pkg::SPAN_RST;
         min_gap_ff   <= ros_pkg::MIN_GAP_RST;
         step_ff      <= ros_pkg::STEP_RST;
      end else begin
         state_ff <= state_in;
         if (req_accept && action_in == ros_pkg::ACT_ACTIVITY) begin
            cursor_ff <= '0;
         end else if (req_accept && action_in == ros_pkg::ACT_DISPLACE && cursor_open) begin
            cursor_ff <= cursor_ff + CW'(1);
         end
         if (state_ff == ros_pkg::ST_RESP && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ros_pkg::CSR_SPAN:    span_ff    <= csr_data;
               ros_pkg::CSR_MIN_GAP: min_gap_ff <= csr_data;
               ros_pkg::CSR_STEP:    step_ff    <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         idx_addr_ff  <= idx_addr_in;
         rd_ok_ff     <= (action_in == ros_pkg::ACT_READ) && idx_ok_in;
         p_addr_ff    <= p_in;
         nbr_addr_ff  <= nbr_in;
         prev_addr_ff <= prev_in;
         kind_ff      <= kind_in;
         prod_ff      <= ros_pkg::PROD_W'(step_ff) * ros_pkg::PROD_W'(req_rnd);
         res_moved_ff <= 1'b0;
         res_err_ff   <= (action_in == ros_pkg::ACT_DISPLACE) && !cursor_open;
         res_done_ff  <= (action_in == ros_pkg::ACT_DISPLACE) &&
                         (!cursor_open || cursor_ff == CURSOR_END - CW'(1));
         count_ff     <= '0;
      end
      case (state_ff)
         ros_pkg::ST_ACT_BASE: begin
            wrap_ff     <= wrap_close;
            cprev_ff    <= wrap_close;
            prev_pos_ff <= rd_b_ff;
            k_ff        <= AW'(1);
         end
         ros_pkg::ST_ACT_RUN: begin
            cprev_ff    <= gap_close;
            prev_pos_ff <= rd_a_ff;
            count_ff    <= count_ff + ros_pkg::CNT_W'(flag_wdata);
            k_ff        <= k_ff + AW'(1);
         end
         ros_pkg::ST_ACT_END:    count_ff <= count_ff + ros_pkg::CNT_W'(flag_wdata);
         ros_pkg::ST_DISP_LOAD:  res_moved_ff <= flag_rd_ff;
         ros_pkg::ST_DISP_ORDER: begin
            wp_ff <= wp_in;
            wb_ff <= wb_in;
            wm_ff <= wm_in;
         end
         ros_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_read_value_ff   <= rd_ok_ff ? rd_a_ff : '0;
               rsp_active_count_ff <= count_ff;
               rsp_moved_ff        <= res_moved_ff;
               rsp_sweep_done_ff   <= res_done_ff;
               rsp_error_ff        <= res_err_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_read_value_ff;
   assign rsp_active_count = rsp_active_count_ff;
   assign rsp_moved        = rsp_moved_ff;
   assign rsp_sweep_done   = rsp_sweep_done_ff;
   assign rsp_error        = rsp_error_ff;

   // ---------------------------------------------------------------- assertions
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CURSOR_END)
      else $error("sweep cursor beyond particle count");

   a_activity_opens: assert property (@(posedge clock) disable iff (reset)
      (req_accept && action_in == ros_pkg::ACT_ACTIVITY) |=> (cursor_ff == '0))
      else $error("activity pass did not open a sweep");

   a_no_write_in_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ros_pkg::ST_RESP) |-> !pos_we)
      else $error("position write while holding a result");

   a_idle_particle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ros_pkg::ST_DISP_LOAD && !flag_rd_ff) |=>
         (state_ff == ros_pkg::ST_RESP && !res_moved_ff))
      else $error("inactive particle was moved");

   a_error_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_error_ff || (rsp_sweep_done_ff && !rsp_moved_ff)))
      else $error("error result with inconsistent flags");

endmodule
